[hw/rtl/gma_pkg.sv]
// shared types, constants and arithmetic helpers of the gram moment accumulator
package gma_pkg;

  // field widths
  localparam int SAMPLE_FIELDS   = 4;
  localparam int MAX_COLUMNS_DEF = 4;
  localparam int SAMPLE_W        = 16;
  localparam int PROD_W          = 32;
  localparam int ACC_W           = 64;
  localparam int COUNT_W         = 32;
  localparam int IDX_W           = 4;
  localparam int CFG_W           = 3;
  localparam int REQ_W           = 2;

  // configuration port
  localparam int ADDR_W             = 3;
  localparam int DATA_W             = 32;
  localparam int REG_COLUMNS_IN_USE = 0;
  localparam logic [CFG_W-1:0] COLUMNS_RESET = 3'd4;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  // readout sequencer states
  typedef enum logic [1:0] {
    RD_IDLE,
    RD_COUNT,
    RD_LINEAR,
    RD_PAIR
  } rd_state_t;

  // saturating sum with its overflow mark
  typedef struct packed {
    logic             ovf;
    logic [ACC_W-1:0] sum;
  } sat_sum_t;

  // 64-bit signed add that clamps at the limits
  function automatic sat_sum_t sat_add(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b);
    logic [ACC_W-1:0] r;
    sat_sum_t         res;
    r       = a + b;
    res.ovf = (a[ACC_W-1] == b[ACC_W-1]) && (r[ACC_W-1] != a[ACC_W-1]);
    if (res.ovf) begin
      res.sum = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      res.sum = r;
    end
    return res;
  endfunction

  // fixed slot of column pair (j,k), j <= k, row-major in an ncol triangle
  function automatic int pair_slot(input int j, input int k, input int ncol);
    return j * ncol - (j * (j - 1)) / 2 + (k - j);
  endfunction

endpackage

[hw/rtl/gram_moment_accumulator.sv]
// gram moment accumulator: row count, linear sums and pairwise product sums
//
// Request channel (req_valid / req_stall): one transaction per unstalled cycle,
// req_type add, read or clear, with four signed Q8.8 samples. Results leave
// on the stat channel (stat_valid / stat_stall), one statistic per transaction.
// The samples pass an input register and a product register (all column pair
// products in parallel), then the saturating accumulators. Add and clear pass
// both registers and emit nothing; rows go in one per cycle outside a readout.
// A read emits count, linear sums, then product sums, 1 + c + c(c+1)/2
// transactions for c active columns; the first leaves through the sequencer
// and the output register, then one per cycle while the receiver takes them.
// While a readout runs the accumulator stage holds, so req_stall rises once
// the two stages ahead of it are full. A stat_stall holds the output register
// and with it the readout sequencer.
// Reset clears all sums, the count and the overflow flag at once and sets
// columns_in_use to 4; columns_in_use is written over the APB port at 0x0.
module gram_moment_accumulator
  import gma_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready,
  // request channel
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [REQ_W-1:0]           req_type,
  input  logic signed [SAMPLE_W-1:0] sample_0,
  input  logic signed [SAMPLE_W-1:0] sample_1,
  input  logic signed [SAMPLE_W-1:0] sample_2,
  input  logic signed [SAMPLE_W-1:0] sample_3,
  // statistic channel
  output logic                       stat_valid,
  input  logic                       stat_stall,
  output logic [IDX_W-1:0]           stat_index,
  output logic signed [ACC_W-1:0]    stat_value,
  output logic                       overflow_seen,
  output logic                       last_of_run
);

  localparam int NCOL   = (MAX_COLUMNS < SAMPLE_FIELDS) ? MAX_COLUMNS : SAMPLE_FIELDS;
  localparam int NPAIR  = (NCOL * (NCOL + 1)) / 2;
  localparam int COL_W  = (NCOL > 1) ? $clog2(NCOL) : 1;
  localparam int SLOT_W = (NPAIR > 1) ? $clog2(NPAIR) : 1;

  // configuration register
  logic [CFG_W-1:0] columns_in_use;
  logic [CFG_W-1:0] active_cols;
  logic             cfg_hit;

  // pipeline stages
  logic                       s1_valid;
  logic [REQ_W-1:0]           s1_req;
  logic signed [SAMPLE_W-1:0] s1_samp [NCOL];
  logic                       s2_valid;
  logic [REQ_W-1:0]           s2_req;
  logic signed [SAMPLE_W-1:0] s2_samp [NCOL];
  logic signed [PROD_W-1:0]   s2_prod [NPAIR];
  logic                       s2_adv;
  logic                       s2_take;
  logic signed [SAMPLE_W-1:0] in_samp [SAMPLE_FIELDS];

  // accumulators
  logic [COUNT_W-1:0] row_count, row_count_next;
  logic [ACC_W-1:0]   linear_sums [NCOL];
  logic [ACC_W-1:0]   linear_sums_next [NCOL];
  logic [ACC_W-1:0]   product_sums [NPAIR];
  logic [ACC_W-1:0]   product_sums_next [NPAIR];
  logic               overflow_sticky, overflow_sticky_next;

  // readout sequencer
  rd_state_t        rd_state, rd_state_next;
  logic [COL_W-1:0] rd_j, rd_j_next;
  logic [COL_W-1:0] rd_k, rd_k_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic             out_free;
  logic             emit;
  logic [ACC_W-1:0] emit_value;
  logic             emit_last;
  logic [SLOT_W-1:0] rd_slot;

  // apb register access
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[ADDR_W-1:2] == 1'(REG_COLUMNS_IN_USE));
  assign prdata  = cfg_hit ? {{(DATA_W-CFG_W){1'b0}}, columns_in_use} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= COLUMNS_RESET;
    end else if (psel && penable && pwrite && cfg_hit) begin
      columns_in_use <= pwdata[CFG_W-1:0];
    end
  end

  // active column count, capped at the stored columns
  assign active_cols = (columns_in_use > CFG_W'(NCOL)) ? CFG_W'(NCOL) : columns_in_use;

  // stage handshake
  assign s2_take   = s2_valid && (rd_state == RD_IDLE);
  assign s2_adv    = !s2_valid || (rd_state == RD_IDLE);
  assign req_stall = s1_valid && !s2_adv;

  assign in_samp[0] = sample_0;
  assign in_samp[1] = sample_1;
  assign in_samp[2] = sample_2;
  assign in_samp[3] = sample_3;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s1_req <= req_type;
      for (int j = 0; j < NCOL; j++) begin
        s1_samp[j] <= in_samp[j];
      end
    end
  end

  // product register: every column pair multiplied in parallel
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      s2_req <= s1_req;
      for (int j = 0; j < NCOL; j++) begin
        s2_samp[j] <= s1_samp[j];
        for (int k = j; k < NCOL; k++) begin
          s2_prod[pair_slot(j, k, NCOL)] <= $signed(s1_samp[j]) * $signed(s1_samp[k]);
        end
      end
    end
  end

  // saturating accumulate, clear
  always_comb begin
    sat_sum_t ls;
    ls                   = '0;
    row_count_next       = row_count;
    linear_sums_next     = linear_sums;
    product_sums_next    = product_sums;
    overflow_sticky_next = overflow_sticky;
    if (s2_take) begin
      case (s2_req)
        REQ_ADD: begin
          if (row_count == '1) begin
            overflow_sticky_next = 1'b1;
          end else begin
            row_count_next = row_count + 1'b1;
          end
          for (int j = 0; j < NCOL; j++) begin
            if (CFG_W'(j) < active_cols) begin
              ls = sat_add(linear_sums[j], ACC_W'(s2_samp[j]));
              linear_sums_next[j] = ls.sum;
              if (ls.ovf) begin
                overflow_sticky_next = 1'b1;
              end
            end
          end
          for (int j = 0; j < NCOL; j++) begin
            for (int k = j; k < NCOL; k++) begin
              if (CFG_W'(k) < active_cols) begin
                ls = sat_add(product_sums[pair_slot(j, k, NCOL)],
                             ACC_W'(s2_prod[pair_slot(j, k, NCOL)]));
                product_sums_next[pair_slot(j, k, NCOL)] = ls.sum;
                if (ls.ovf) begin
                  overflow_sticky_next = 1'b1;
                end
              end
            end
          end
        end
        REQ_CLEAR: begin
          row_count_next       = '0;
          overflow_sticky_next = 1'b0;
          for (int j = 0; j < NCOL; j++) begin
            linear_sums_next[j] = '0;
          end
          for (int p = 0; p < NPAIR; p++) begin
            product_sums_next[p] = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count       <= '0;
      overflow_sticky <= 1'b0;
      for (int j = 0; j < NCOL; j++) begin
        linear_sums[j] <= '0;
      end
      for (int p = 0; p < NPAIR; p++) begin
        product_sums[p] <= '0;
      end
    end else begin
      row_count       <= row_count_next;
      overflow_sticky <= overflow_sticky_next;
      linear_sums     <= linear_sums_next;
      product_sums    <= product_sums_next;
    end
  end

  // readout sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_state <= RD_IDLE;
      rd_j     <= '0;
      rd_k     <= '0;
      rd_idx   <= '0;
    end else begin
      rd_state <= rd_state_next;
      rd_j     <= rd_j_next;
      rd_k     <= rd_k_next;
      rd_idx   <= rd_idx_next;
    end
  end

  assign out_free = !stat_valid || !stat_stall;
  assign rd_slot  = SLOT_W'(pair_slot(int'(rd_j), int'(rd_k), NCOL));

  // readout next state and the statistic to emit
  always_comb begin
    rd_state_next = rd_state;
    rd_j_next     = rd_j;
    rd_k_next     = rd_k;
    rd_idx_next   = rd_idx;
    emit          = 1'b0;
    emit_value    = '0;
    emit_last     = 1'b0;
    case (rd_state)
      RD_IDLE: begin
        if (s2_take && (s2_req == REQ_READ)) begin
          rd_state_next = RD_COUNT;
          rd_idx_next   = '0;
        end
      end
      RD_COUNT: begin
        emit       = out_free;
        emit_value = {{(ACC_W-COUNT_W){1'b0}}, row_count};
        emit_last  = (active_cols == '0);
        if (out_free) begin
          rd_idx_next   = rd_idx + 1'b1;
          rd_j_next     = '0;
          rd_state_next = emit_last ? RD_IDLE : RD_LINEAR;
        end
      end
      RD_LINEAR: begin
        emit       = out_free;
        emit_value = linear_sums[rd_j];
        if (out_free) begin
          rd_idx_next = rd_idx + 1'b1;
          if (CFG_W'(rd_j) == active_cols - 1'b1) begin
            rd_state_next = RD_PAIR;
            rd_j_next     = '0;
            rd_k_next     = '0;
          end else begin
            rd_j_next = rd_j + 1'b1;
          end
        end
      end
      RD_PAIR: begin
        emit       = out_free;
        emit_value = product_sums[rd_slot];
        emit_last  = (CFG_W'(rd_j) == active_cols - 1'b1) &&
                     (CFG_W'(rd_k) == active_cols - 1'b1);
        if (out_free) begin
          rd_idx_next = rd_idx + 1'b1;
          if (emit_last) begin
            rd_state_next = RD_IDLE;
          end else if (CFG_W'(rd_k) == active_cols - 1'b1) begin
            rd_j_next = rd_j + 1'b1;
            rd_k_next = rd_j + 1'b1;
          end else begin
            rd_k_next = rd_k + 1'b1;
          end
        end
      end
      default: rd_state_next = RD_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      stat_valid <= 1'b0;
    end else if (out_free) begin
      stat_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      stat_index    <= rd_idx;
      stat_value    <= emit_value;
      overflow_seen <= overflow_sticky;
      last_of_run   <= emit_last;
    end
  end

endmodule

[hw/rtl/gma_checker.sv]
// port-level checks of the gram moment accumulator, bound to the top level
module gma_checker
  import gma_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       stat_valid,
  input logic                       stat_stall,
  input logic [IDX_W-1:0]           stat_index,
  input logic signed [ACC_W-1:0]    stat_value,
  input logic                       overflow_seen,
  input logic                       last_of_run
);

  // a readout runs without gaps and counts up by one
  assert property (@(posedge clk) disable iff (rst)
    (stat_valid && !stat_stall && !last_of_run) |=>
      (stat_valid && stat_index == $past(stat_index) + 4'd1))
    else $error("readout broke its index sequence");

  // overflow flag does not change inside one readout
  assert property (@(posedge clk) disable iff (rst)
    (stat_valid && !stat_stall && !last_of_run) |=> (overflow_seen == $past(overflow_seen)))
    else $error("overflow flag changed within a readout");

  // the count is zero-extended
  assert property (@(posedge clk) disable iff (rst)
    (stat_valid && stat_index == 4'd0) |-> (stat_value[63:32] == 32'd0))
    else $error("row count has upper bits set");

  // a readout ends only after a full triangle
  assert property (@(posedge clk) disable iff (rst)
    (stat_valid && last_of_run) |->
      (stat_index == 4'd0 || stat_index == 4'd2 || stat_index == 4'd5 ||
       stat_index == 4'd9 || stat_index == 4'd14))
    else $error("readout ended at an impossible index");

  // a stalled statistic holds
  assert property (@(posedge clk) disable iff (rst)
    (stat_valid && stat_stall) |=>
      (stat_valid && $stable(stat_index) && $stable(stat_value) &&
       $stable(last_of_run) && $stable(overflow_seen)))
    else $error("stalled statistic changed");

endmodule

bind gram_moment_accumulator gma_checker u_gma_checker (
  .clk           (clk),
  .rst           (rst),
  .stat_valid    (stat_valid),
  .stat_stall    (stat_stall),
  .stat_index    (stat_index),
  .stat_value    (stat_value),
  .overflow_seen (overflow_seen),
  .last_of_run   (last_of_run)
);
